// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of i_clk, skipped while in reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Check that one condition implies a second one in the next cycle.
`define ASSERT_NEXT(label, cond, expr, msg) \
    `ASSERT_CLK(label, (cond) |=> (expr), msg)

`endif

// ===== hw/rtl/mlcd_pkg.sv =====
// Package for the memory LCD frame serializer: sizes, codes and helpers.
`timescale 1ns / 1ps

package mlcd_pkg;

    localparam int NUM_LINES      = 96;
    localparam int BYTES_PER_LINE = 12;
    localparam int STORE_DEPTH    = NUM_LINES * BYTES_PER_LINE;
    localparam int ADDR_W         = $clog2(STORE_DEPTH);
    localparam int LINE_W         = 7;
    localparam int COL_W          = 4;
    localparam int CMD_W          = 2;
    localparam int BYTE_W         = 8;
    localparam int S_TDATA_W      = 24;

    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FILL  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_NEXT  = 2'd2;

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_ADDR   = 2'd1;
    localparam logic [1:0] PH_DATA   = 2'd2;
    localparam logic [1:0] PH_EOL    = 2'd3;

    localparam logic [BYTE_W-1:0] HDR_BASE  = 8'h80;
    localparam logic [BYTE_W-1:0] VCOM_MASK = 8'h40;
    localparam logic [BYTE_W-1:0] ZERO_BYTE = 8'h00;

    function automatic logic [BYTE_W-1:0] bit_rev8(input logic [BYTE_W-1:0] v);
        logic [BYTE_W-1:0] r;
        for (int i = 0; i < BYTE_W; i++) begin
            r[i] = v[BYTE_W-1-i];
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/mlcd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module mlcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1152
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

// ===== hw/rtl/memory_lcd_frame_serializer.sv =====
// Top level: frame store and memory LCD write-frame byte sequencer.
//
//  channel   dir  handshake          payload
//  s         in   i_s_tvalid/o_s_tready  i_s_tdata: command, line, column, data
//  m         out  o_m_tvalid/i_m_tready  o_m_tdata: byte; o_m_tuser: first, last
//  cfg       in   i_cfg_wr_en        i_cfg_wr_data: vcom bit
//
// Write: at accept. Next: byte registered, store bytes via ST_READ (registered RAM read).
// Fill: STORE_DEPTH (1152) entries, one RAM entry per cycle via the sweep counter.
// After reset the same sweep clears the store, with o_s_tready low.
// A new transaction is taken only once the previous result has been sent.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module memory_lcd_frame_serializer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // [1:0] command, [8:2] line_index,
                                     // [12:9] column_index, [20:13] data_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [7:0] out_byte
    output logic [1:0]  o_m_tuser,   // [0] frame_first, [1] frame_last
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data
);

    localparam int AW = mlcd_pkg::ADDR_W;
    localparam int BW = mlcd_pkg::BYTE_W;
    localparam int LW = mlcd_pkg::LINE_W;
    localparam int CW = mlcd_pkg::COL_W;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;

    logic [1:0]    r_state, n_state;
    logic [1:0]    r_phase, n_phase;
    logic [LW-1:0] r_line, n_line;
    logic [CW-1:0] r_slot, n_slot;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [AW-1:0] r_sweep, n_sweep;
    logic [BW-1:0] r_fill_val, n_fill_val;
    logic          r_vcom;
    logic          r_out_valid, n_out_valid;
    logic [BW-1:0] r_out_byte, n_out_byte;
    logic          r_first, n_first;
    logic          r_last, n_last;

    logic [mlcd_pkg::CMD_W-1:0] s_cmd;
    logic [LW-1:0]              s_line;
    logic [CW-1:0]              s_col;
    logic [BW-1:0]              s_data;
    logic                       s_accept;
    logic [CW-1:0]              slot_inc;

    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    logic [BW-1:0] ram_wr_data;
    logic [BW-1:0] ram_rd_data;

    assign s_cmd  = i_s_tdata[1:0];
    assign s_line = i_s_tdata[8:2];
    assign s_col  = i_s_tdata[12:9];
    assign s_data = i_s_tdata[20:13];

    assign o_s_tready = (r_state == ST_IDLE) && !r_out_valid;
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign slot_inc   = r_slot + CW'(1);

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_byte;
    assign o_m_tuser  = {r_last, r_first};

    always_comb begin
        if (r_state == ST_CLEAR) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = r_sweep;
            ram_wr_data = r_fill_val;
        end else begin
            ram_wr_en   = s_accept && (s_cmd == mlcd_pkg::CMD_WRITE)
                          && (s_line < LW'(mlcd_pkg::NUM_LINES))
                          && (s_col < CW'(mlcd_pkg::BYTES_PER_LINE));
            ram_wr_addr = AW'(s_line) * AW'(mlcd_pkg::BYTES_PER_LINE) + AW'(s_col);
            ram_wr_data = s_data;
        end
    end

    mlcd_ram #(
        .WIDTH(BW),
        .DEPTH(mlcd_pkg::STORE_DEPTH)
    ) u_store (
        .i_clk    (i_clk),
        .i_wr_en  (ram_wr_en),
        .i_wr_addr(ram_wr_addr),
        .i_wr_data(ram_wr_data),
        .i_rd_addr(r_rd_ptr),
        .o_rd_data(ram_rd_data)
    );

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_line      = r_line;
        n_slot      = r_slot;
        n_rd_ptr    = r_rd_ptr;
        n_sweep     = r_sweep;
        n_fill_val  = r_fill_val;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_byte  = r_out_byte;
        n_first     = r_first;
        n_last      = r_last;

        unique case (r_state)
            ST_CLEAR: begin
                n_sweep = r_sweep + AW'(1);
                if (r_sweep == AW'(mlcd_pkg::STORE_DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_accept && s_cmd == mlcd_pkg::CMD_FILL) begin
                    n_state    = ST_CLEAR;
                    n_sweep    = '0;
                    n_fill_val = s_data;
                end else if (s_accept && s_cmd == mlcd_pkg::CMD_NEXT) begin
                    n_first = 1'b0;
                    n_last  = 1'b0;
                    unique case (r_phase)
                        mlcd_pkg::PH_HEADER: begin
                            n_out_valid = 1'b1;
                            n_out_byte  = mlcd_pkg::HDR_BASE
                                          | (r_vcom ? mlcd_pkg::VCOM_MASK
                                                    : mlcd_pkg::ZERO_BYTE);
                            n_first     = 1'b1;
                            n_line      = '0;
                            n_slot      = '0;
                            n_rd_ptr    = '0;
                            n_phase     = mlcd_pkg::PH_ADDR;
                        end
                        mlcd_pkg::PH_ADDR: begin
                            n_out_valid = 1'b1;
                            n_slot      = '0;
                            if (r_line < LW'(mlcd_pkg::NUM_LINES)) begin
                                n_out_byte = mlcd_pkg::bit_rev8(BW'(r_line) + BW'(1));
                                n_phase    = mlcd_pkg::PH_DATA;
                            end else begin
                                n_out_byte = mlcd_pkg::ZERO_BYTE;
                                n_last     = 1'b1;
                                n_line     = '0;
                                n_phase    = mlcd_pkg::PH_HEADER;
                            end
                        end
                        mlcd_pkg::PH_DATA: begin
                            // store byte comes out of the RAM next cycle
                            n_state  = ST_READ;
                            n_rd_ptr = r_rd_ptr + AW'(1);
                            if (slot_inc >= CW'(mlcd_pkg::BYTES_PER_LINE)
                                || slot_inc == '0) begin
                                n_slot  = '0;
                                n_phase = mlcd_pkg::PH_EOL;
                            end else begin
                                n_slot = slot_inc;
                            end
                        end
                        default: begin
                            n_out_valid = 1'b1;
                            n_out_byte  = mlcd_pkg::ZERO_BYTE;
                            n_line      = r_line + LW'(1);
                            n_phase     = mlcd_pkg::PH_ADDR;
                        end
                    endcase
                end
            end
            ST_READ: begin
                n_state     = ST_IDLE;
                n_out_valid = 1'b1;
                n_out_byte  = ram_rd_data;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_phase     <= mlcd_pkg::PH_HEADER;
            r_line      <= '0;
            r_slot      <= '0;
            r_rd_ptr    <= '0;
            r_sweep     <= '0;
            r_fill_val  <= '0;
            r_vcom      <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_line      <= n_line;
            r_slot      <= n_slot;
            r_rd_ptr    <= n_rd_ptr;
            r_sweep     <= n_sweep;
            r_fill_val  <= n_fill_val;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_vcom <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_byte <= n_out_byte;
        r_first    <= n_first;
        r_last     <= n_last;
    end

    `ASSERT_NEXT(a_read_gives_result, r_state == ST_READ, r_out_valid,
        "store read did not produce a result")
    `ASSERT_CLK(a_flags_exclusive, !(r_out_valid && r_first && r_last),
        "header and trailer flags set together")
    `ASSERT_CLK(a_line_in_range,
        (r_phase == mlcd_pkg::PH_DATA || r_phase == mlcd_pkg::PH_EOL)
        |-> (r_line < LW'(mlcd_pkg::NUM_LINES)),
        "line counter past last line inside a line")
    `ASSERT_CLK(a_read_phase,
        r_state == ST_READ
        |-> (r_phase == mlcd_pkg::PH_DATA || r_phase == mlcd_pkg::PH_EOL),
        "store read outside a data run")

endmodule

// ===== tb/sv/tb_memory_lcd_frame_serializer.sv =====
// Testbench for the memory LCD frame serializer: directed and random commands checked against a predictor.
`timescale 1ns / 1ps

module tb_memory_lcd_frame_serializer;

    localparam logic [mlcd_pkg::CMD_W-1:0] CMD_NONE = 2'd3;
    localparam int FRAME_LEN    = 2 + mlcd_pkg::NUM_LINES * (mlcd_pkg::BYTES_PER_LINE + 2);
    localparam int SETTLE_LEN   = mlcd_pkg::STORE_DEPTH + 16;
    localparam int CYCLE_LIMIT  = 600000;

    typedef struct packed {
        logic [mlcd_pkg::CMD_W-1:0]  cmd;
        logic [mlcd_pkg::LINE_W-1:0] line;
        logic [mlcd_pkg::COL_W-1:0]  col;
        logic [mlcd_pkg::BYTE_W-1:0] data;
    } t_lcd_cmd;

    typedef struct {
        logic [mlcd_pkg::BYTE_W-1:0] out_byte;
        logic                        first;
        logic                        last;
    } t_frame_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [23:0] i_s_tdata = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [7:0]  o_m_tdata;
    logic [1:0]  o_m_tuser;
    logic        i_cfg_wr_en = 1'b0;
    logic        i_cfg_wr_data = 1'b0;

    memory_lcd_frame_serializer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata),
        .o_m_tuser     (o_m_tuser),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // frame predictor state
    logic [mlcd_pkg::BYTE_W-1:0] shadow_store [mlcd_pkg::STORE_DEPTH];
    logic [1:0]                  shadow_phase = mlcd_pkg::PH_HEADER;
    logic [mlcd_pkg::LINE_W-1:0] shadow_line = '0;
    logic [mlcd_pkg::COL_W-1:0]  shadow_slot = '0;
    logic                        shadow_vcom = 1'b1;

    t_lcd_cmd    pending_cmds [$];
    t_frame_byte expected_bytes [$];

    int  next_issued = 0;
    int  idle_odds = 0;
    bit  calm = 1'b0;
    bit  s_taken = 1'b0;
    int  s_gap = 0;
    int  m_gap = 0;
    int  cycle_count = 0;
    int  error_count = 0;

    initial begin
        foreach (shadow_store[k]) shadow_store[k] = '0;
    end

    function automatic void apply_command(t_lcd_cmd c);
        t_frame_byte fb;
        fb.out_byte = mlcd_pkg::ZERO_BYTE;
        fb.first = 1'b0;
        fb.last = 1'b0;
        case (c.cmd)
            mlcd_pkg::CMD_WRITE: begin
                if (c.line < mlcd_pkg::NUM_LINES && c.col < mlcd_pkg::BYTES_PER_LINE)
                    shadow_store[int'(c.line) * mlcd_pkg::BYTES_PER_LINE + int'(c.col)] = c.data;
            end
            mlcd_pkg::CMD_FILL: begin
                foreach (shadow_store[k]) shadow_store[k] = c.data;
            end
            mlcd_pkg::CMD_NEXT: begin
                case (shadow_phase)
                    mlcd_pkg::PH_HEADER: begin
                        fb.out_byte = mlcd_pkg::HDR_BASE
                                      | (shadow_vcom ? mlcd_pkg::VCOM_MASK
                                                     : mlcd_pkg::ZERO_BYTE);
                        fb.first = 1'b1;
                        shadow_line = '0;
                        shadow_slot = '0;
                        shadow_phase = mlcd_pkg::PH_ADDR;
                    end
                    mlcd_pkg::PH_ADDR: begin
                        if (shadow_line < mlcd_pkg::NUM_LINES) begin
                            logic [mlcd_pkg::BYTE_W-1:0] addr;
                            addr = mlcd_pkg::BYTE_W'(shadow_line) + 1'b1;
                            for (int b = 0; b < mlcd_pkg::BYTE_W; b++)
                                fb.out_byte[b] = addr[mlcd_pkg::BYTE_W-1-b];
                            shadow_slot = '0;
                            shadow_phase = mlcd_pkg::PH_DATA;
                        end else begin
                            fb.last = 1'b1;
                            shadow_line = '0;
                            shadow_slot = '0;
                            shadow_phase = mlcd_pkg::PH_HEADER;
                        end
                    end
                    mlcd_pkg::PH_DATA: begin
                        if (shadow_line < mlcd_pkg::NUM_LINES
                            && shadow_slot < mlcd_pkg::BYTES_PER_LINE)
                            fb.out_byte = shadow_store[int'(shadow_line)
                                                       * mlcd_pkg::BYTES_PER_LINE
                                                       + int'(shadow_slot)];
                        shadow_slot = shadow_slot + 1'b1;
                        if (shadow_slot >= mlcd_pkg::BYTES_PER_LINE || shadow_slot == 0) begin
                            shadow_slot = '0;
                            shadow_phase = mlcd_pkg::PH_EOL;
                        end
                    end
                    default: begin
                        shadow_line = shadow_line + 1'b1;
                        shadow_phase = mlcd_pkg::PH_ADDR;
                    end
                endcase
                expected_bytes.push_back(fb);
            end
            default: ;
        endcase
    endfunction

    function automatic void queue_cmd(logic [mlcd_pkg::CMD_W-1:0] cmd, int line, int col,
                                      int data);
        t_lcd_cmd c;
        c.cmd = cmd;
        c.line = mlcd_pkg::LINE_W'(line);
        c.col = mlcd_pkg::COL_W'(col);
        c.data = mlcd_pkg::BYTE_W'(data);
        pending_cmds.push_back(c);
        if (cmd == mlcd_pkg::CMD_NEXT) next_issued++;
    endfunction

    task automatic queue_random(int count);
        int odds_pick;
        int r;
        int done;
        while (pending_cmds.size() != 0) @(posedge i_clk);
        odds_pick = $urandom_range(0, 3);
        idle_odds = (odds_pick == 0) ? 0 : (odds_pick == 1) ? 5 : (odds_pick == 2) ? 20 : 45;
        done = 0;
        while (done < count) begin
            r = $urandom_range(0, 999);
            if (r < 5) begin
                queue_cmd(mlcd_pkg::CMD_FILL, $urandom_range(0, 127), $urandom_range(0, 15),
                          $urandom_range(0, 255));
                done++;
            end else if (r < 20) begin
                // ignored command, not counted
                queue_cmd(CMD_NONE, $urandom_range(0, 127), $urandom_range(0, 15),
                          $urandom_range(0, 255));
            end else if (r < 35) begin
                queue_cmd(mlcd_pkg::CMD_WRITE, $urandom_range(0, 127), $urandom_range(0, 15),
                          $urandom_range(0, 255));
                done++;
            end else if (r < 160) begin
                queue_cmd(mlcd_pkg::CMD_WRITE, $urandom_range(0, mlcd_pkg::NUM_LINES - 1),
                          $urandom_range(0, mlcd_pkg::BYTES_PER_LINE - 1),
                          $urandom_range(0, 255));
                done++;
            end else begin
                queue_cmd(mlcd_pkg::CMD_NEXT, $urandom_range(0, 127), $urandom_range(0, 15),
                          $urandom_range(0, 255));
                done++;
            end
        end
    endtask

    task automatic drain_and_settle();
        while (pending_cmds.size() != 0 || expected_bytes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_LEN) @(negedge i_clk);
    endtask

    task automatic write_vcom(logic value);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= value;
        shadow_vcom = value;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // driver: sender and receiver, both change on the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            i_m_tready <= 1'b0;
        end else begin
            if (!(i_s_tvalid && !s_taken)) begin
                if (s_gap != 0) begin
                    s_gap--;
                    i_s_tvalid <= 1'b0;
                end else if (pending_cmds.size() != 0) begin
                    if (!calm && idle_odds != 0 && $urandom_range(1, 100) <= idle_odds) begin
                        s_gap = $urandom_range(1, 12) - 1;
                        i_s_tvalid <= 1'b0;
                    end else begin
                        i_s_tvalid <= 1'b1;
                        i_s_tdata <= {3'b000, pending_cmds[0].data, pending_cmds[0].col,
                                      pending_cmds[0].line, pending_cmds[0].cmd};
                    end
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
            s_taken = 1'b0;

            if (m_gap != 0) begin
                m_gap--;
                i_m_tready <= 1'b0;
            end else if (!calm && idle_odds != 0 && $urandom_range(1, 100) <= idle_odds) begin
                m_gap = $urandom_range(1, 12) - 1;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // monitor: sample both handshakes on the rising edge
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                if (expected_bytes.size() == 0) begin
                    $error("unexpected result transaction: out_byte %h", o_m_tdata);
                    error_count++;
                end else begin
                    t_frame_byte exp_b;
                    exp_b = expected_bytes.pop_front();
                    if (o_m_tdata !== exp_b.out_byte) begin
                        $error("out_byte: expected %h, got %h", exp_b.out_byte, o_m_tdata);
                        error_count++;
                    end
                    if (o_m_tuser[0] !== exp_b.first) begin
                        $error("frame_first: expected %b, got %b", exp_b.first, o_m_tuser[0]);
                        error_count++;
                    end
                    if (o_m_tuser[1] !== exp_b.last) begin
                        $error("frame_last: expected %b, got %b", exp_b.last, o_m_tuser[1]);
                        error_count++;
                    end
                end
            end
            if (i_s_tvalid && o_s_tready) begin
                apply_command(pending_cmds.pop_front());
                s_taken = 1'b1;
            end
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: header, writes mid-frame, range limits, ignored command, fill
        idle_odds = 20;
        queue_cmd(mlcd_pkg::CMD_NEXT, 0, 0, 0);
        queue_cmd(mlcd_pkg::CMD_NEXT, 0, 0, 0);
        queue_cmd(mlcd_pkg::CMD_WRITE, 0, 0, 8'hFF);
        queue_cmd(mlcd_pkg::CMD_WRITE, 0, mlcd_pkg::BYTES_PER_LINE - 1, 8'hA5);
        queue_cmd(mlcd_pkg::CMD_WRITE, mlcd_pkg::NUM_LINES - 1, mlcd_pkg::BYTES_PER_LINE - 1,
                  8'hFF);
        queue_cmd(mlcd_pkg::CMD_WRITE, mlcd_pkg::NUM_LINES, 0, 8'h55);
        queue_cmd(mlcd_pkg::CMD_WRITE, 0, mlcd_pkg::BYTES_PER_LINE, 8'h55);
        queue_cmd(mlcd_pkg::CMD_WRITE, 127, 15, 8'hAA);
        queue_cmd(CMD_NONE, 127, 15, 8'hFF);
        repeat (mlcd_pkg::BYTES_PER_LINE) queue_cmd(mlcd_pkg::CMD_NEXT, 0, 0, 0);
        queue_cmd(mlcd_pkg::CMD_NEXT, 0, 0, 0);
        queue_cmd(mlcd_pkg::CMD_FILL, 0, 0, 8'hFF);
        queue_cmd(mlcd_pkg::CMD_NEXT, 0, 0, 0);
        queue_cmd(mlcd_pkg::CMD_NEXT, 0, 0, 0);
        drain_and_settle();

        // run past the trailer so the next header shows the new polarity
        write_vcom(1'b0);
        while (next_issued < FRAME_LEN + 40) queue_random(150);
        drain_and_settle();

        write_vcom(1'b1);
        queue_random(150);
        while (pending_cmds.size() != 0) @(posedge i_clk);
        calm = 1'b1;
        queue_random(100);

        while (pending_cmds.size() != 0 || expected_bytes.size() != 0) @(posedge i_clk);
        repeat (32) @(posedge i_clk);
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
